[rtl/core/mmc_pkg.sv]
package mmc_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FRACTION_BITS_DEF     = 16;
    localparam int ATAN_ENTRIES          = 24;
    localparam int ANGLE_UP_SHIFT        = 16;

    // converged CORDIC gain, Q2.30
    localparam longint GAIN_Q30 = 652032874;

    // arctangent per step, 2^-22 degree units
    localparam logic signed [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    localparam logic signed [16:0] TURN_UNITS          = 17'sd23040;
    localparam logic signed [16:0] NEG_TURN_UNITS      = -17'sd23040;
    localparam logic signed [16:0] TWO_TURN_UNITS      = 17'sd46080;
    localparam logic signed [16:0] HALF_TURN_UNITS     = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN_UNITS  = 17'sd5760;
    localparam logic signed [16:0] THREE_QUARTER_UNITS = 17'sd17280;

    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
    localparam logic        [1:0]  ROW_LAST  = 2'd3;

    typedef struct packed {
        logic signed [31:0] translate_x;
        logic signed [31:0] translate_y;
        logic signed [31:0] translate_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic        [15:0] uniform_scale;
    } t_in;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] col_zero;
        logic signed [31:0] col_one;
        logic signed [31:0] col_two;
        logic signed [31:0] col_three;
        logic               last_row;
    } t_out;

    // fields that ride alongside the angle pipeline
    typedef struct packed {
        logic signed [31:0] translate_x;
        logic signed [31:0] translate_y;
        logic signed [31:0] translate_z;
        logic        [15:0] uniform_scale;
    } t_side;

endpackage

[rtl/core/model_matrix_compose.sv]
// Path: an accepted input word runs through the three CORDIC lanes, mmc_block and
//   mmc_rows to its first row word; rows follow one a cycle while i_ready is high.
// Output: each transform leaves as four row words through the single output port;
//   the pipeline takes a new word each cycle when free.
// Reset: synchronous active-low i_rst_n clears all valid bits and the row
//   counter; the datapath registers are not reset.
module model_matrix_compose #(
    parameter int CORDIC_ITERATIONS = mmc_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRACTION_BITS     = mmc_pkg::FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mmc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mmc_pkg::t_out o_data
);

    localparam int W  = FRACTION_BITS + 3;
    localparam int CL = CORDIC_ITERATIONS + 2;

    logic                en;
    logic [2:0]          cor_vld;
    logic signed [W-1:0] cor_sin [3];
    logic signed [W-1:0] cor_cos [3];
    logic signed [15:0]  angle [3];
    mmc_pkg::t_side      r_sb [CL];
    mmc_pkg::t_side      n_sb;
    logic                blk_vld;
    logic signed [31:0]  blk_elem [9];
    mmc_pkg::t_side      blk_side;
    logic                load_ready;

    // whole pipeline advances together; it only holds when a finished word waits
    assign en      = !blk_vld || load_ready;
    assign o_ready = en;

    assign angle[0] = i_data.angle_x;
    assign angle[1] = i_data.angle_y;
    assign angle[2] = i_data.angle_z;

    for (genvar a = 0; a < 3; a++) begin : g_lane
        mmc_cordic #(
            .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
            .FRACTION_BITS    (FRACTION_BITS)
        ) u_cordic (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(i_valid),
            .i_angle(angle[a]),
            .o_valid(cor_vld[a]),
            .o_sin  (cor_sin[a]),
            .o_cos  (cor_cos[a])
        );
    end

    assign n_sb.translate_x   = i_data.translate_x;
    assign n_sb.translate_y   = i_data.translate_y;
    assign n_sb.translate_z   = i_data.translate_z;
    assign n_sb.uniform_scale = i_data.uniform_scale;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb;
            for (int k = 1; k < CL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    mmc_block #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_block (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(cor_vld[0]),
        .i_sin  (cor_sin),
        .i_cos  (cor_cos),
        .i_side (r_sb[CL-1]),
        .o_valid(blk_vld),
        .o_elem (blk_elem),
        .o_side (blk_side)
    );

    mmc_rows u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_valid(blk_vld),
        .i_elem      (blk_elem),
        .i_side      (blk_side),
        .o_load_ready(load_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

[rtl/core/mmc_cordic.sv]
module mmc_cordic #(
    parameter int CORDIC_ITERATIONS = mmc_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRACTION_BITS     = mmc_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [15:0]            i_angle,
    output logic                          o_valid,
    output logic signed [FRACTION_BITS+2:0] o_sin,
    output logic signed [FRACTION_BITS+2:0] o_cos
);

    localparam int N  = CORDIC_ITERATIONS;
    localparam int F  = FRACTION_BITS;
    localparam int W  = F + 3;
    localparam int ZW = 32;
    localparam longint XI_FULL =
        (mmc_pkg::GAIN_Q30 + ((64'sd1 <<< (30 - F)) >>> 1)) >>> (30 - F);
    localparam logic signed [W-1:0] X_INIT = W'(XI_FULL);

    logic signed [16:0]   a_ext;
    logic signed [16:0]   a_mod;
    logic signed [16:0]   a_fold;
    logic                 fold_flip;
    logic signed [ZW-1:0] n_z0;

    logic [N+1:0]         r_vld;
    logic                 r_flip [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic signed [W-1:0]  r_x [0:N-1];
    logic signed [W-1:0]  r_y [0:N-1];
    logic signed [W-1:0]  r_sin;
    logic signed [W-1:0]  r_cos;

    // reduce to one turn, then fold into [-90, 90] degrees
    always_comb begin
        a_ext = {i_angle[15], i_angle};
        priority if (a_ext >= mmc_pkg::TURN_UNITS) begin
            a_mod = a_ext - mmc_pkg::TURN_UNITS;
        end else if (a_ext < mmc_pkg::NEG_TURN_UNITS) begin
            a_mod = a_ext + mmc_pkg::TWO_TURN_UNITS;
        end else if (a_ext < 17'sd0) begin
            a_mod = a_ext + mmc_pkg::TURN_UNITS;
        end else begin
            a_mod = a_ext;
        end
        fold_flip = 1'b0;
        priority if (a_mod > mmc_pkg::QUARTER_TURN_UNITS
                     && a_mod <= mmc_pkg::THREE_QUARTER_UNITS) begin
            a_fold    = a_mod - mmc_pkg::HALF_TURN_UNITS;
            fold_flip = 1'b1;
        end else if (a_mod > mmc_pkg::THREE_QUARTER_UNITS) begin
            a_fold = a_mod - mmc_pkg::TURN_UNITS;
        end else begin
            a_fold = a_mod;
        end
        n_z0 = ZW'(a_fold) <<< mmc_pkg::ANGLE_UP_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= n_z0;
            r_flip[0] <= fold_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [W-1:0]  x_in;
        logic signed [W-1:0]  y_in;
        logic signed [W-1:0]  dx;
        logic signed [W-1:0]  dy;
        if (i == 0) begin : g_first
            assign x_in = X_INIT;
            assign y_in = '0;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i]   <= x_in - dx;
                    r_y[i]   <= y_in + dy;
                    r_z[i+1] <= r_z[i] - mmc_pkg::ATAN_TABLE[i];
                end else begin
                    r_x[i]   <= x_in + dx;
                    r_y[i]   <= y_in - dy;
                    r_z[i+1] <= r_z[i] + mmc_pkg::ATAN_TABLE[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_flip[N] ? -r_y[N-1] : r_y[N-1];
            r_cos <= r_flip[N] ? -r_x[N-1] : r_x[N-1];
        end
    end

    assign o_valid = r_vld[N+1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

[rtl/core/mmc_block.sv]
module mmc_block #(
    parameter int FRACTION_BITS = mmc_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [FRACTION_BITS+2:0] i_sin [3],
    input  logic signed [FRACTION_BITS+2:0] i_cos [3],
    input  mmc_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic signed [31:0]              o_elem [9],
    output mmc_pkg::t_side                  o_side
);

    localparam int F  = FRACTION_BITS;
    localparam int W  = F + 3;
    localparam int EW = W + 1;
    localparam int PW = (EW + 17 > 34) ? EW + 17 : 34;
    localparam int SH = F - 8;
    localparam logic signed [2*W-1:0] HALF_F = (2*W)'(1) << (F - 1);
    localparam logic signed [PW-1:0]  HALF_S = (PW'(1) << SH) >> 1;
    localparam logic signed [PW-1:0]  S_MAX  = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0]  S_MIN  = PW'(-64'sd2147483648);

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = (2*W)'(a) * (2*W)'(b);
        p = p + HALF_F;
        return W'(p >>> F);
    endfunction

    function automatic logic signed [31:0] scale_sat(input logic signed [EW-1:0] e,
                                                     input logic [15:0] s);
        logic signed [PW-1:0] v;
        v = PW'(e) * PW'(signed'({1'b0, s}));
        v = (v + HALF_S) >>> SH;
        if (v > S_MAX) begin
            v = S_MAX;
        end else if (v < S_MIN) begin
            v = S_MIN;
        end
        return 32'(v);
    endfunction

    logic [3:0] r_vld;
    mmc_pkg::t_side r_side [4];

    // stage 1: pairwise products and single factors carried forward
    logic signed [W-1:0] r1_cycz, r1_cysz, r1_sxsy, r1_cxsz, r1_cxcz;
    logic signed [W-1:0] r1_cxsy, r1_sxcy, r1_sxsz, r1_sxcz, r1_cxcy;
    logic signed [W-1:0] r1_sy, r1_cz, r1_sz;
    // stage 2: three-term products and carried pairwise terms
    logic signed [W-1:0] r2_sxsycz, r2_sxsysz, r2_cxsycz, r2_cxsysz;
    logic signed [W-1:0] r2_cycz, r2_cysz, r2_sy, r2_cxsz, r2_cxcz;
    logic signed [W-1:0] r2_sxcy, r2_sxsz, r2_sxcz, r2_cxcy;
    // stage 3: rotation block
    logic signed [EW-1:0] r3_e [9];
    // stage 4: scaled, saturated
    logic signed [31:0]   r4_e [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];

            r1_cycz <= fmul(i_cos[1], i_cos[2]);
            r1_cysz <= fmul(i_cos[1], i_sin[2]);
            r1_sxsy <= fmul(i_sin[0], i_sin[1]);
            r1_cxsz <= fmul(i_cos[0], i_sin[2]);
            r1_cxcz <= fmul(i_cos[0], i_cos[2]);
            r1_cxsy <= fmul(i_cos[0], i_sin[1]);
            r1_sxcy <= fmul(i_sin[0], i_cos[1]);
            r1_sxsz <= fmul(i_sin[0], i_sin[2]);
            r1_sxcz <= fmul(i_sin[0], i_cos[2]);
            r1_cxcy <= fmul(i_cos[0], i_cos[1]);
            r1_sy   <= i_sin[1];
            r1_cz   <= i_cos[2];
            r1_sz   <= i_sin[2];

            r2_sxsycz <= fmul(r1_sxsy, r1_cz);
            r2_sxsysz <= fmul(r1_sxsy, r1_sz);
            r2_cxsycz <= fmul(r1_cxsy, r1_cz);
            r2_cxsysz <= fmul(r1_cxsy, r1_sz);
            r2_cycz   <= r1_cycz;
            r2_cysz   <= r1_cysz;
            r2_sy     <= r1_sy;
            r2_cxsz   <= r1_cxsz;
            r2_cxcz   <= r1_cxcz;
            r2_sxcy   <= r1_sxcy;
            r2_sxsz   <= r1_sxsz;
            r2_sxcz   <= r1_sxcz;
            r2_cxcy   <= r1_cxcy;

            r3_e[0] <= EW'(r2_cycz);
            r3_e[1] <= -EW'(r2_cysz);
            r3_e[2] <= EW'(r2_sy);
            r3_e[3] <= EW'(r2_sxsycz) + EW'(r2_cxsz);
            r3_e[4] <= EW'(r2_cxcz) - EW'(r2_sxsysz);
            r3_e[5] <= -EW'(r2_sxcy);
            r3_e[6] <= EW'(r2_sxsz) - EW'(r2_cxsycz);
            r3_e[7] <= EW'(r2_cxsysz) + EW'(r2_sxcz);
            r3_e[8] <= EW'(r2_cxcy);

            for (int k = 0; k < 9; k++) begin
                r4_e[k] <= scale_sat(r3_e[k], r_side[2].uniform_scale);
            end
        end
    end

    assign o_valid = r_vld[3];
    assign o_side  = r_side[3];
    assign o_elem  = r4_e;

endmodule

[rtl/core/mmc_rows.sv]
module mmc_rows (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  logic signed [31:0] i_elem [9],
    input  mmc_pkg::t_side     i_side,
    output logic               o_load_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output mmc_pkg::t_out      o_data
);

    logic               r_full;
    logic [1:0]         r_row;
    logic signed [31:0] r_elem [9];
    logic signed [31:0] r_trans [3];
    logic               take;
    logic               done;

    assign take         = r_full && i_ready;
    assign done         = take && (r_row == mmc_pkg::ROW_LAST);
    assign o_load_ready = !r_full || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_row  <= '0;
        end else if (i_load_valid && o_load_ready) begin
            r_full <= 1'b1;
            r_row  <= '0;
        end else if (take) begin
            r_row <= r_row + 2'd1;
            if (done) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_load_ready) begin
            r_elem     <= i_elem;
            r_trans[0] <= i_side.translate_x;
            r_trans[1] <= i_side.translate_y;
            r_trans[2] <= i_side.translate_z;
        end
    end

    always_comb begin
        o_data.row_index = r_row;
        o_data.last_row  = (r_row == mmc_pkg::ROW_LAST);
        unique case (r_row)
            2'd0: begin
                o_data.col_zero  = r_elem[0];
                o_data.col_one   = r_elem[1];
                o_data.col_two   = r_elem[2];
                o_data.col_three = r_trans[0];
            end
            2'd1: begin
                o_data.col_zero  = r_elem[3];
                o_data.col_one   = r_elem[4];
                o_data.col_two   = r_elem[5];
                o_data.col_three = r_trans[1];
            end
            2'd2: begin
                o_data.col_zero  = r_elem[6];
                o_data.col_one   = r_elem[7];
                o_data.col_two   = r_elem[8];
                o_data.col_three = r_trans[2];
            end
            default: begin
                o_data.col_zero  = '0;
                o_data.col_one   = '0;
                o_data.col_two   = '0;
                o_data.col_three = mmc_pkg::ONE_Q16;
            end
        endcase
    end

    assign o_valid = r_full;

endmodule

[rtl/core/mmc_checker.sv]
module mmc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_ready,
    input mmc_pkg::t_out o_data
);

    // rows of one matrix leave in order, back to back on the port
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_data.row_index != mmc_pkg::ROW_LAST)
        |=> o_valid && (o_data.row_index == $past(o_data.row_index) + 2'd1))
        else $error("row index did not advance");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_row == (o_data.row_index == mmc_pkg::ROW_LAST)))
        else $error("last_row flag disagrees with row index");

    a_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_row
        |-> o_data.col_zero == '0 && o_data.col_one == '0 && o_data.col_two == '0
            && o_data.col_three == mmc_pkg::ONE_Q16)
        else $error("bottom row is not 0 0 0 1");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

endmodule

bind model_matrix_compose mmc_checker u_mmc_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int ITERS = mmc_pkg::CORDIC_ITERATIONS_DEF;
    localparam int FRAC  = mmc_pkg::FRACTION_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LATENCY = ITERS + 7;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    mmc_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    mmc_pkg::t_out o_data;

    mmc_pkg::t_out row_queue[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   quiet = 0;

    always #5 i_clk = ~i_clk;

    model_matrix_compose dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic trig(input logic signed [15:0] ang, output longint sn, output longint cs);
        longint r, x, y, z, dx, dy;
        bit flip;
        int n;
        r = longint'(ang) % 23040;
        flip = 0;
        if (r < 0) r += 23040;
        if (r > 5760 && r <= 17280) begin
            r -= 11520;
            flip = 1;
        end else if (r > 17280) begin
            r -= 23040;
        end
        z = r <<< mmc_pkg::ANGLE_UP_SHIFT;
        x = round_sh(mmc_pkg::GAIN_Q30, 30 - FRAC);
        y = 0;
        n = (ITERS > mmc_pkg::ATAN_ENTRIES) ? mmc_pkg::ATAN_ENTRIES : ITERS;
        for (int i = 0; i < n; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(mmc_pkg::ATAN_TABLE[i]);
            end else begin
                x += dx; y -= dy; z += longint'(mmc_pkg::ATAN_TABLE[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endtask

    function automatic longint fmul(longint a, longint b);
        return round_sh(a * b, FRAC);
    endfunction

    function automatic logic signed [31:0] scale_elem(longint e, longint s);
        longint v;
        int sh;
        v = e * s;
        sh = FRAC + 8 - 16;
        if (sh > 0) v = round_sh(v, sh);
        else if (sh < 0) v = v <<< (-sh);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_rows(input mmc_pkg::t_in w);
        longint sx, cx, sy, cy, sz, cz, sc;
        longint blk[3][3];
        mmc_pkg::t_out row;
        trig(w.angle_x, sx, cx);
        trig(w.angle_y, sy, cy);
        trig(w.angle_z, sz, cz);
        sc = longint'(w.uniform_scale);
        blk[0][0] = fmul(cy, cz);
        blk[0][1] = -fmul(cy, sz);
        blk[0][2] = sy;
        blk[1][0] = fmul(fmul(sx, sy), cz) + fmul(cx, sz);
        blk[1][1] = fmul(cx, cz) - fmul(fmul(sx, sy), sz);
        blk[1][2] = -fmul(sx, cy);
        blk[2][0] = fmul(sx, sz) - fmul(fmul(cx, sy), cz);
        blk[2][1] = fmul(fmul(cx, sy), sz) + fmul(sx, cz);
        blk[2][2] = fmul(cx, cy);
        for (int r = 0; r < 3; r++) begin
            row.row_index = r[1:0];
            row.col_zero  = scale_elem(blk[r][0], sc);
            row.col_one   = scale_elem(blk[r][1], sc);
            row.col_two   = scale_elem(blk[r][2], sc);
            row.col_three = (r == 0) ? w.translate_x :
                            (r == 1) ? w.translate_y : w.translate_z;
            row.last_row  = 1'b0;
            row_queue.push_back(row);
        end
        row.row_index = mmc_pkg::ROW_LAST;
        row.col_zero = '0;
        row.col_one = '0;
        row.col_two = '0;
        row.col_three = mmc_pkg::ONE_Q16;
        row.last_row = 1'b1;
        row_queue.push_back(row);
    endtask

    // receiver stall pattern and row checker
    always @(posedge i_clk) begin
        mmc_pkg::t_out exp_row;
        if (i_rst_n && o_valid && i_ready) begin
            if (row_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row word %p", o_data);
            end else begin
                exp_row = row_queue.pop_front();
                if (o_data !== exp_row) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: expected %p actual %p", exp_row, o_data);
                end
            end
        end
        i_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays up after a word is taken; the next call or drain() changes it
    task automatic send_word(input mmc_pkg::t_in w);
        if (!quiet) begin
            while ($urandom_range(99) < 20) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_rows(w);
    endtask

    function automatic mmc_pkg::t_in mk(int tx, int ty, int tz, int ax, int ay, int az, int s);
        mmc_pkg::t_in w;
        w.translate_x = tx; w.translate_y = ty; w.translate_z = tz;
        w.angle_x = 16'(ax); w.angle_y = 16'(ay); w.angle_z = 16'(az);
        w.uniform_scale = 16'(s);
        return w;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(46080) - 23040);
            1: return 16'($urandom_range(16) - 8 + 5760 * $urandom_range(8) - 23040);
            default: return 16'($urandom_range(46080) - 23040);
        endcase
    endfunction

    function automatic mmc_pkg::t_in rand_word();
        mmc_pkg::t_in w;
        w.translate_x = $urandom;
        w.translate_y = $urandom;
        w.translate_z = $urandom;
        w.angle_x = rand_angle();
        w.angle_y = rand_angle();
        w.angle_z = rand_angle();
        case ($urandom_range(4))
            0: w.uniform_scale = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: w.uniform_scale = 16'h0100;
            default: w.uniform_scale = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (row_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(mk(0, 0, 0, 0, 0, 0, 256));
        send_word(mk(32'h7FFFFFFF, 32'h80000000, -1, 0, 0, 0, 0));
        send_word(mk(1, 2, 3, 23040, -23040, 0, 65535));
        send_word(mk(0, 0, 0, 5760, 5761, -5760, 256));
        send_word(mk(0, 0, 0, -5761, 17280, 17281, 256));
        send_word(mk(0, 0, 0, 11520, -11520, 32767, 65535));
        send_word(mk(0, 0, 0, -32768, 32767, -32768, 65535));
        send_word(mk(65536, -65536, 7, 2880, 1440, 720, 512));
        send_word(mk(0, 0, 0, -2880, -1440, -720, 65535));
        send_word(mk(5, 6, 7, 23039, -23039, 1, 1));
        send_word(mk(0, 0, 0, 100, 200, 300, 0));
    endtask

    task automatic test_drain_pause();
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_word(rand_word());
    endtask

    task automatic test_random();
        for (int i = 0; i < 450; i++) begin
            quiet = (i >= 150 && i < 230);
            send_word(rand_word());
        end
        quiet = 0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random();
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && row_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mmc_pkg.sv
rtl/core/mmc_cordic.sv
rtl/core/mmc_block.sv
rtl/core/mmc_rows.sv
rtl/core/model_matrix_compose.sv
rtl/core/mmc_checker.sv
tb/tb.sv
